// ----- design/cts_pkg.sv -----
// ============================================================================
// cts_pkg
// Shared types, codes and constants of the CSMA transmit sequencer.
// ============================================================================
package cts_pkg;

    // Field widths
    localparam int unsigned OPCODE_W  = 2;
    localparam int unsigned LEN_W     = 10;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned RND_W     = 8;
    localparam int unsigned ACTION_W  = 3;
    localparam int unsigned OFFSET_W  = 9;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned STCODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DW    = 16;

    // Default frame buffer size in bytes
    localparam int unsigned BUFFER_BYTES_DEF = 512;

    // Register reset values
    localparam logic [7:0]  SLOT_TIME_RST    = 8'd10;
    localparam logic [7:0]  PERSISTENCE_RST  = 8'd63;
    localparam logic [15:0] KEYUP_DELAY_RST  = 16'd25;
    localparam logic [7:0]  TAIL_TIME_RST    = 8'd4;

    // Item kinds on the input channel
    typedef enum logic [OPCODE_W-1:0] {
        OP_FRAME_READY = 2'd0,
        OP_TIMER_TICK  = 2'd1,
        OP_TX_READY    = 2'd2
    } opcode_t;

    // Commands for the line
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_KEY_ON  = 3'd1,
        ACT_KEY_OFF = 3'd2,
        ACT_START   = 3'd3,
        ACT_DATA    = 3'd4,
        ACT_END     = 3'd5,
        ACT_REWIND  = 3'd6
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_TIME   = 3'd0,
        CFG_PERSISTENCE = 3'd1,
        CFG_KEYUP_DELAY = 3'd2,
        CFG_TAIL_TIME   = 3'd3,
        CFG_FULL_DUPLEX = 3'd4
    } cfg_idx_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        SEQ_IDLE   = 6'b000001,
        SEQ_WAIT   = 6'b000010,
        SEQ_DELAY  = 6'b000100,
        SEQ_ACTIVE = 6'b001000,
        SEQ_FLUSH  = 6'b010000,
        SEQ_TAIL   = 6'b100000
    } seq_state_t;

    // Reported state codes
    localparam logic [STCODE_W-1:0] CODE_IDLE   = 3'd0;
    localparam logic [STCODE_W-1:0] CODE_WAIT   = 3'd1;
    localparam logic [STCODE_W-1:0] CODE_DELAY  = 3'd2;
    localparam logic [STCODE_W-1:0] CODE_ACTIVE = 3'd3;
    localparam logic [STCODE_W-1:0] CODE_FLUSH  = 3'd4;
    localparam logic [STCODE_W-1:0] CODE_TAIL   = 3'd5;

    typedef struct packed {
        logic [7:0]  slot_time;
        logic [7:0]  persistence;
        logic [15:0] keyup_delay;
        logic [7:0]  tail_time;
        logic        full_duplex;
    } cfg_t;

    typedef struct packed {
        seq_state_t         seq;
        logic [TICK_W-1:0]  countdown;
        logic [LEN_W-1:0]   send_index;
        logic [LEN_W-1:0]   pending_length;
        logic [COUNT_W-1:0] underruns;
        logic               abort_armed;
    } seq_ctx_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [LEN_W-1:0]    frame_length;
        logic [TICK_W-1:0]   elapsed_ticks;
        logic [RND_W-1:0]    random_byte;
        logic                carrier_detect;
        logic                tx_underrun;
    } item_t;

    typedef struct packed {
        action_t             action;
        logic [OFFSET_W-1:0] byte_offset;
        logic                frame_taken;
        logic                transmitter_keyed;
        logic                abort_on_underrun;
        logic [COUNT_W-1:0]  underrun_count;
        logic [STCODE_W-1:0] sequencer_state;
    } result_t;

    // Zero-valued timer settings behave as one tick.
    function automatic logic [TICK_W-1:0] at_least_one8(input logic [7:0] v);
        at_least_one8 = (v == 8'd0) ? TICK_W'(1) : TICK_W'(v);
    endfunction

    function automatic logic [TICK_W-1:0] at_least_one16(input logic [15:0] v);
        at_least_one16 = (v == 16'd0) ? TICK_W'(1) : v;
    endfunction

    // Numeric state code for the status field.
    function automatic logic [STCODE_W-1:0] state_code(input seq_state_t s);
        case (s)
            SEQ_IDLE:   state_code = CODE_IDLE;
            SEQ_WAIT:   state_code = CODE_WAIT;
            SEQ_DELAY:  state_code = CODE_DELAY;
            SEQ_ACTIVE: state_code = CODE_ACTIVE;
            SEQ_FLUSH:  state_code = CODE_FLUSH;
            SEQ_TAIL:   state_code = CODE_TAIL;
            default:    state_code = CODE_IDLE;
        endcase
    endfunction

endpackage

// ----- design/cts_step.sv -----
// ============================================================================
// cts_step
// Next-state and command logic of the sequencer for one registered item.
// ============================================================================
module cts_step #(
    parameter int unsigned BUFFER_BYTES = cts_pkg::BUFFER_BYTES_DEF
) (
    input  cts_pkg::cfg_t     cfg,
    input  cts_pkg::seq_ctx_t cur,
    input  cts_pkg::item_t    item,
    output cts_pkg::seq_ctx_t nxt,
    output cts_pkg::result_t  res
);

    // Longest frame that the length field and the buffer both allow.
    localparam int unsigned LenMax = (1 << cts_pkg::LEN_W) - 1;
    localparam int unsigned SatLen = (BUFFER_BYTES > LenMax) ? LenMax : BUFFER_BYTES;
    localparam logic [cts_pkg::LEN_W-1:0] SAT_LEN = cts_pkg::LEN_W'(SatLen);

    cts_pkg::action_t           act;
    logic [cts_pkg::LEN_W-1:0]  offset;
    logic                       taken;
    logic [cts_pkg::LEN_W-1:0]  index_inc;
    logic                       slot_won;

    assign index_inc = cur.send_index + cts_pkg::LEN_W'(1);

    // Channel is ours when full duplex, or when clear and the dice allow it.
    assign slot_won = cfg.full_duplex ||
                      (!item.carrier_detect && (item.random_byte <= cfg.persistence));

    // Decode the item against the current state.
    always_comb begin
        nxt    = cur;
        act    = cts_pkg::ACT_NONE;
        offset = '0;
        taken  = 1'b0;
        case (item.opcode)
            cts_pkg::OP_FRAME_READY: begin
                // Accept a new frame only when none is pending.
                if ((cur.pending_length == '0) && (item.frame_length != '0)) begin
                    nxt.pending_length = (item.frame_length > SAT_LEN) ? SAT_LEN
                                                                       : item.frame_length;
                    nxt.send_index = '0;
                    taken = 1'b1;
                    if (cur.seq == cts_pkg::SEQ_IDLE) begin
                        nxt.countdown = cfg.full_duplex ? cts_pkg::TICK_W'(1)
                                                        : cts_pkg::at_least_one8(cfg.slot_time);
                        nxt.seq = cts_pkg::SEQ_WAIT;
                    end else if (cur.seq == cts_pkg::SEQ_TAIL) begin
                        nxt.countdown = cts_pkg::TICK_W'(1);
                        nxt.seq = cts_pkg::SEQ_DELAY;
                    end
                end
            end
            cts_pkg::OP_TIMER_TICK: begin
                // The single timer paces channel wait, key-up delay and tail.
                if (cur.countdown != '0) begin
                    if (cur.countdown <= item.elapsed_ticks) begin
                        nxt.countdown = '0;
                        case (cur.seq)
                            cts_pkg::SEQ_WAIT: begin
                                if (slot_won) begin
                                    act = cts_pkg::ACT_KEY_ON;
                                    nxt.countdown = cts_pkg::at_least_one16(cfg.keyup_delay);
                                    nxt.seq = cts_pkg::SEQ_DELAY;
                                end else begin
                                    nxt.countdown = cts_pkg::at_least_one8(cfg.slot_time);
                                end
                            end
                            cts_pkg::SEQ_DELAY: begin
                                act = cts_pkg::ACT_START;
                                offset = cur.send_index;
                                nxt.send_index = index_inc;
                                nxt.seq = cts_pkg::SEQ_ACTIVE;
                            end
                            cts_pkg::SEQ_TAIL: begin
                                act = cts_pkg::ACT_KEY_OFF;
                                nxt.seq = cts_pkg::SEQ_IDLE;
                            end
                            default: ;
                        endcase
                    end else begin
                        nxt.countdown = cur.countdown - item.elapsed_ticks;
                    end
                end
            end
            cts_pkg::OP_TX_READY: begin
                case (cur.seq)
                    cts_pkg::SEQ_ACTIVE: begin
                        if (item.tx_underrun) begin
                            nxt.underruns = cur.underruns + cts_pkg::COUNT_W'(1);
                            nxt.send_index = '0;
                            nxt.seq = cts_pkg::SEQ_FLUSH;
                            act = cts_pkg::ACT_REWIND;
                        end else if (cur.send_index >= cur.pending_length) begin
                            nxt.abort_armed = 1'b0;
                            nxt.seq = cts_pkg::SEQ_FLUSH;
                            nxt.pending_length = '0;
                            act = cts_pkg::ACT_END;
                        end else begin
                            act = cts_pkg::ACT_DATA;
                            offset = cur.send_index;
                            nxt.send_index = index_inc;
                        end
                    end
                    cts_pkg::SEQ_FLUSH: begin
                        // Restart the frame, or fall into the tail when done.
                        nxt.abort_armed = 1'b1;
                        if (cur.send_index < cur.pending_length) begin
                            act = cts_pkg::ACT_START;
                            offset = cur.send_index;
                            nxt.send_index = index_inc;
                            nxt.seq = cts_pkg::SEQ_ACTIVE;
                        end else begin
                            nxt.countdown = cts_pkg::at_least_one8(cfg.tail_time);
                            nxt.seq = cts_pkg::SEQ_TAIL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Result item: command plus status after the update.
    always_comb begin
        res.action            = act;
        res.byte_offset       = offset[cts_pkg::OFFSET_W-1:0];
        res.frame_taken       = taken;
        res.transmitter_keyed = (nxt.seq != cts_pkg::SEQ_IDLE);
        res.abort_on_underrun = nxt.abort_armed;
        res.underrun_count    = nxt.underruns;
        res.sequencer_state   = cts_pkg::state_code(nxt.seq);
    end

endmodule

// ----- design/csma_transmit_sequencer.sv -----
// ============================================================================
// csma_transmit_sequencer
// Transmit control of a packet-radio HDLC link with p-persistent access.
// ============================================================================
// Every input item yields exactly one result item. An accepted item is held in
// an input register, the sequencer state is updated from it combinationally
// and its result is captured in the result register; one item can be accepted
// in every clock cycle while the result channel does not stall. While a result
// waits to be taken the input register keeps its item and the input channel
// stalls, and both sides may stall freely. Configuration registers take effect
// on the next item processed; the user must see that they are written only while
// no item is in flight, as the block itself does not enforce this.
module csma_transmit_sequencer #(
    parameter int unsigned BUFFER_BYTES = cts_pkg::BUFFER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [cts_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [cts_pkg::CFG_DW-1:0]    cfg_wdata,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame_length[9:0], elapsed_ticks[25:10], random_byte[33:26],
    // carrier_detect[34], tx_underrun[35], zero[39:36]
    input  logic [39:0]                   s_tdata,
    // opcode[1:0]
    input  logic [1:0]                    s_tuser,
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // byte_offset[8:0], frame_taken[9], transmitter_keyed[10],
    // abort_on_underrun[11], underrun_count[27:12], sequencer_state[30:28],
    // zero[31]
    output logic [31:0]                   m_tdata,
    // action[2:0]
    output logic [2:0]                    m_tuser
);

    cts_pkg::cfg_t     cfg_reg;
    cts_pkg::seq_ctx_t ctx_reg;
    cts_pkg::seq_ctx_t ctx_next;
    cts_pkg::item_t    item_reg;
    logic              in_valid_reg;
    cts_pkg::result_t  res_next;
    cts_pkg::result_t  res_reg;
    logic              out_valid_reg;
    logic              advance;

    // An item moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slot_time   <= cts_pkg::SLOT_TIME_RST;
            cfg_reg.persistence <= cts_pkg::PERSISTENCE_RST;
            cfg_reg.keyup_delay <= cts_pkg::KEYUP_DELAY_RST;
            cfg_reg.tail_time   <= cts_pkg::TAIL_TIME_RST;
            cfg_reg.full_duplex <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                cts_pkg::CFG_SLOT_TIME:   cfg_reg.slot_time   <= cfg_wdata[7:0];
                cts_pkg::CFG_PERSISTENCE: cfg_reg.persistence <= cfg_wdata[7:0];
                cts_pkg::CFG_KEYUP_DELAY: cfg_reg.keyup_delay <= cfg_wdata;
                cts_pkg::CFG_TAIL_TIME:   cfg_reg.tail_time   <= cfg_wdata[7:0];
                cts_pkg::CFG_FULL_DUPLEX: cfg_reg.full_duplex <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode         <= s_tuser;
            item_reg.frame_length   <= s_tdata[9:0];
            item_reg.elapsed_ticks  <= s_tdata[25:10];
            item_reg.random_byte    <= s_tdata[33:26];
            item_reg.carrier_detect <= s_tdata[34];
            item_reg.tx_underrun    <= s_tdata[35];
        end
    end

    // Sequencer update for the registered item.
    cts_step #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_step (
        .cfg (cfg_reg),
        .cur (ctx_reg),
        .item(item_reg),
        .nxt (ctx_next),
        .res (res_next)
    );

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg.seq            <= cts_pkg::SEQ_IDLE;
            ctx_reg.countdown      <= '0;
            ctx_reg.send_index     <= '0;
            ctx_reg.pending_length <= '0;
            ctx_reg.underruns      <= '0;
            ctx_reg.abort_armed    <= 1'b1;
        end else if (advance) begin
            ctx_reg <= ctx_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.action;
    assign m_tdata  = {1'b0,
                       res_reg.sequencer_state,
                       res_reg.underrun_count,
                       res_reg.abort_on_underrun,
                       res_reg.transmitter_keyed,
                       res_reg.frame_taken,
                       res_reg.byte_offset};

`ifndef SYNTH
    // An idle sequencer holds neither a frame nor a running timer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctx_reg.seq == cts_pkg::SEQ_IDLE) |->
            (ctx_reg.pending_length == '0) && (ctx_reg.countdown == '0))
        else $error("idle sequencer with pending frame or running timer");

    // While sending, the byte index never runs past the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctx_reg.seq == cts_pkg::SEQ_ACTIVE) |->
            (ctx_reg.send_index <= ctx_reg.pending_length))
        else $error("send index beyond pending frame length");

    // The underrun counter only moves when an item is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (ctx_reg.underruns != $past(ctx_reg.underruns))) |->
            $past(advance))
        else $error("underrun counter changed without an item");
`endif

endmodule

// ----- tb/csma_transmit_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// csma_transmit_sequencer_tb
// Self-checking bench for the CSMA transmit sequencer. A driver feeds frame
// offers, timer ticks and transmitter-ready events from a queue, a predictor
// works out the line command and status for every accepted item, and a
// monitor compares each result item with the oldest prediction. The run goes
// through several register settings and three patterns of stalls.
// ============================================================================
module csma_transmit_sequencer_tb;

    localparam logic [cts_pkg::OPCODE_W-1:0] OP_RESERVED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned ITEMS_PER_PHASE = 92;

    // Block inputs, all known from time zero
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [cts_pkg::CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [cts_pkg::CFG_DW-1:0]    cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic [39:0]                   s_tdata   = '0;
    logic [1:0]                    s_tuser   = '0;
    logic                          m_tready  = 1'b0;

    // Block outputs
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    // Events waiting to be sent and line commands waiting to be seen
    cts_pkg::item_t   tx_events_q[$];
    cts_pkg::result_t line_cmds_q[$];

    // Own copy of the registers and of the sequencer state
    cts_pkg::cfg_t                chan_cfg;
    logic [cts_pkg::STCODE_W-1:0] seq_code;
    logic [cts_pkg::TICK_W-1:0]   timer_left;
    logic [cts_pkg::LEN_W-1:0]    next_byte;
    logic [cts_pkg::LEN_W-1:0]    frame_len;
    logic [cts_pkg::COUNT_W-1:0]  underrun_tally;
    logic                         rewind_armed;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;

    csma_transmit_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // Timer settings of zero act as a single tick.
    function automatic logic [cts_pkg::TICK_W-1:0] ticks_or_one(input logic [15:0] v);
        return (v == 16'd0) ? cts_pkg::TICK_W'(1) : v;
    endfunction

    // Work out the line command and the status that follow one item.
    function automatic cts_pkg::result_t sequence_line_command(input cts_pkg::item_t it);
        cts_pkg::result_t r;
        r        = '0;
        r.action = cts_pkg::ACT_NONE;
        case (it.opcode)
            cts_pkg::OP_FRAME_READY: begin
                // Only one frame may be pending; empty offers are refused.
                if (frame_len == '0 && it.frame_length != '0) begin
                    frame_len = (it.frame_length > cts_pkg::BUFFER_BYTES_DEF) ?
                                cts_pkg::LEN_W'(cts_pkg::BUFFER_BYTES_DEF) :
                                it.frame_length;
                    next_byte     = '0;
                    r.frame_taken = 1'b1;
                    if (seq_code == cts_pkg::CODE_IDLE) begin
                        timer_left = chan_cfg.full_duplex ? cts_pkg::TICK_W'(1) :
                                     ticks_or_one({8'd0, chan_cfg.slot_time});
                        seq_code   = cts_pkg::CODE_WAIT;
                    end else if (seq_code == cts_pkg::CODE_TAIL) begin
                        timer_left = cts_pkg::TICK_W'(1);
                        seq_code   = cts_pkg::CODE_DELAY;
                    end
                end
            end
            cts_pkg::OP_TIMER_TICK: begin
                if (timer_left != '0) begin
                    if (timer_left <= it.elapsed_ticks) begin
                        timer_left = '0;
                        case (seq_code)
                            cts_pkg::CODE_WAIT: begin
                                // Persistence test on a free channel.
                                if (chan_cfg.full_duplex || (!it.carrier_detect &&
                                    it.random_byte <= chan_cfg.persistence)) begin
                                    r.action   = cts_pkg::ACT_KEY_ON;
                                    timer_left = ticks_or_one(chan_cfg.keyup_delay);
                                    seq_code   = cts_pkg::CODE_DELAY;
                                end else begin
                                    timer_left = ticks_or_one({8'd0, chan_cfg.slot_time});
                                end
                            end
                            cts_pkg::CODE_DELAY: begin
                                r.action      = cts_pkg::ACT_START;
                                r.byte_offset = next_byte[cts_pkg::OFFSET_W-1:0];
                                next_byte     = next_byte + 1'b1;
                                seq_code      = cts_pkg::CODE_ACTIVE;
                            end
                            cts_pkg::CODE_TAIL: begin
                                r.action = cts_pkg::ACT_KEY_OFF;
                                seq_code = cts_pkg::CODE_IDLE;
                            end
                            default: ;
                        endcase
                    end else begin
                        timer_left = timer_left - it.elapsed_ticks;
                    end
                end
            end
            cts_pkg::OP_TX_READY: begin
                case (seq_code)
                    cts_pkg::CODE_ACTIVE: begin
                        if (it.tx_underrun) begin
                            underrun_tally = underrun_tally + 1'b1;
                            next_byte      = '0;
                            seq_code       = cts_pkg::CODE_FLUSH;
                            r.action       = cts_pkg::ACT_REWIND;
                        end else if (next_byte >= frame_len) begin
                            rewind_armed = 1'b0;
                            seq_code     = cts_pkg::CODE_FLUSH;
                            frame_len    = '0;
                            r.action     = cts_pkg::ACT_END;
                        end else begin
                            r.action      = cts_pkg::ACT_DATA;
                            r.byte_offset = next_byte[cts_pkg::OFFSET_W-1:0];
                            next_byte     = next_byte + 1'b1;
                        end
                    end
                    cts_pkg::CODE_FLUSH: begin
                        // Either restart the pending frame or drop into the tail.
                        rewind_armed = 1'b1;
                        if (next_byte < frame_len) begin
                            r.action      = cts_pkg::ACT_START;
                            r.byte_offset = next_byte[cts_pkg::OFFSET_W-1:0];
                            next_byte     = next_byte + 1'b1;
                            seq_code      = cts_pkg::CODE_ACTIVE;
                        end else begin
                            timer_left = ticks_or_one({8'd0, chan_cfg.tail_time});
                            seq_code   = cts_pkg::CODE_TAIL;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.transmitter_keyed = (seq_code != cts_pkg::CODE_IDLE);
        r.abort_on_underrun = rewind_armed;
        r.underrun_count    = underrun_tally;
        r.sequencer_state   = seq_code;
        return r;
    endfunction

    function automatic void push_event(input logic [1:0] op, input logic [9:0] flen,
                                       input logic [15:0] ticks, input logic [7:0] rnd,
                                       input logic busy, input logic under);
        cts_pkg::item_t it;
        it.opcode         = op;
        it.frame_length   = flen;
        it.elapsed_ticks  = ticks;
        it.random_byte    = rnd;
        it.carrier_detect = busy;
        it.tx_underrun    = under;
        tx_events_q.push_back(it);
    endfunction

    // Elapsed counts mostly either small or large enough to expire any timer.
    function automatic logic [15:0] pick_elapsed();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 16'($urandom_range(300));
        else if (sel < 80)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    // A tick whose random byte usually passes the persistence test.
    function automatic void push_tick();
        logic [7:0] rnd;
        rnd = ($urandom_range(9) < 7) ? 8'($urandom_range(chan_cfg.persistence, 0)) :
                                        8'($urandom);
        push_event(cts_pkg::OP_TIMER_TICK, 10'($urandom), pick_elapsed(), rnd,
                   ($urandom_range(9) == 0), 1'($urandom));
    endfunction

    // Mostly whole frame exchanges with random content, some plain noise.
    task automatic queue_traffic(input int unsigned target);
        int unsigned base;
        int unsigned n;
        int unsigned sel;
        logic [9:0]  len;
        base = tx_events_q.size();
        while (tx_events_q.size() - base < target) begin
            sel = $urandom_range(99);
            if (sel < 15) begin
                n = $urandom_range(4, 1);
                repeat (n)
                    push_event(2'($urandom_range(3)), 10'($urandom), 16'($urandom),
                               8'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                sel = $urandom_range(99);
                if (sel < 80)
                    len = 10'($urandom_range(6, 1));
                else if (sel < 97)
                    len = 10'($urandom_range(40, 1));
                else
                    len = 10'($urandom_range(1023));
                push_event(cts_pkg::OP_FRAME_READY, len, 16'($urandom), 8'($urandom),
                           1'($urandom), 1'($urandom));
                repeat ($urandom_range(4, 1))
                    push_tick();
                n = ((len > 40) ? 40 : len) + $urandom_range(3, 1);
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        push_tick();
                    push_event(cts_pkg::OP_TX_READY, 10'($urandom), 16'($urandom),
                               8'($urandom), 1'($urandom), ($urandom_range(24) == 0));
                end
                repeat ($urandom_range(3, 1))
                    push_tick();
            end
        end
    endtask

    // Register write on the configuration port, mirrored in the predictor.
    task automatic write_reg(input cts_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            cts_pkg::CFG_SLOT_TIME:   chan_cfg.slot_time   = val[7:0];
            cts_pkg::CFG_PERSISTENCE: chan_cfg.persistence = val[7:0];
            cts_pkg::CFG_KEYUP_DELAY: chan_cfg.keyup_delay = val;
            cts_pkg::CFG_TAIL_TIME:   chan_cfg.tail_time   = val[7:0];
            cts_pkg::CFG_FULL_DUPLEX: chan_cfg.full_duplex = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Driver: one item at a time, held until the block takes it.
    always @(posedge aclk) begin : driver
        cts_pkg::item_t cur_item;
        logic           holding;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            holding = s_tvalid;
            if (s_tvalid && s_tready) begin
                line_cmds_q.push_back(sequence_line_command(cur_item));
                holding = 1'b0;
            end
            if (!holding) begin
                if (tx_events_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_item = tx_events_q.pop_front();
                    s_tuser  <= cur_item.opcode;
                    s_tdata  <= {4'd0, cur_item.tx_underrun, cur_item.carrier_detect,
                                 cur_item.random_byte, cur_item.elapsed_ticks,
                                 cur_item.frame_length};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result item against the oldest prediction.
    always @(posedge aclk) begin : monitor
        cts_pkg::result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (line_cmds_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result item with none expected: action %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = line_cmds_q.pop_front();
                    compare_field("action", want.action, m_tuser);
                    compare_field("byte_offset", want.byte_offset, m_tdata[8:0]);
                    compare_field("frame_taken", want.frame_taken, m_tdata[9]);
                    compare_field("transmitter_keyed", want.transmitter_keyed, m_tdata[10]);
                    compare_field("abort_on_underrun", want.abort_on_underrun, m_tdata[11]);
                    compare_field("underrun_count", want.underrun_count, m_tdata[27:12]);
                    compare_field("sequencer_state", want.sequencer_state, m_tdata[30:28]);
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** csma_transmit_sequencer: FAILED **");
            $finish;
        end
    end

    // Stimulus sequencing: reset, then one register setting per phase.
    initial begin : stimulus
        int unsigned phase;
        chan_cfg.slot_time   = cts_pkg::SLOT_TIME_RST;
        chan_cfg.persistence = cts_pkg::PERSISTENCE_RST;
        chan_cfg.keyup_delay = cts_pkg::KEYUP_DELAY_RST;
        chan_cfg.tail_time   = cts_pkg::TAIL_TIME_RST;
        chan_cfg.full_duplex = 1'b0;
        seq_code       = cts_pkg::CODE_IDLE;
        timer_left     = '0;
        next_byte      = '0;
        frame_len      = '0;
        underrun_tally = '0;
        rewind_armed   = 1'b1;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            // Receiver stalls most first, then the sender, then neither.
            case (phase / 2)
                0: begin src_idle_pct = 32; snk_idle_pct = 82; end
                1: begin src_idle_pct = 82; snk_idle_pct = 32; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase

            case (phase)
                1: begin
                    write_reg(cts_pkg::CFG_SLOT_TIME, 16'd0);
                    write_reg(cts_pkg::CFG_PERSISTENCE, 16'd255);
                    write_reg(cts_pkg::CFG_KEYUP_DELAY, 16'd0);
                    write_reg(cts_pkg::CFG_TAIL_TIME, 16'd0);
                    write_reg(cts_pkg::CFG_FULL_DUPLEX, 16'd0);
                end
                2: begin
                    write_reg(cts_pkg::CFG_SLOT_TIME, 16'd255);
                    write_reg(cts_pkg::CFG_PERSISTENCE, 16'd0);
                    write_reg(cts_pkg::CFG_KEYUP_DELAY, 16'hffff);
                    write_reg(cts_pkg::CFG_TAIL_TIME, 16'd255);
                end
                3: begin
                    write_reg(cts_pkg::CFG_SLOT_TIME, 16'd3);
                    write_reg(cts_pkg::CFG_PERSISTENCE, 16'd128);
                    write_reg(cts_pkg::CFG_KEYUP_DELAY, 16'd2);
                    write_reg(cts_pkg::CFG_TAIL_TIME, 16'd1);
                    write_reg(cts_pkg::CFG_FULL_DUPLEX, 16'd1);
                end
                4, 5: begin
                    write_reg(cts_pkg::CFG_SLOT_TIME, 16'($urandom_range(20)));
                    write_reg(cts_pkg::CFG_PERSISTENCE, 16'($urandom_range(255)));
                    write_reg(cts_pkg::CFG_KEYUP_DELAY, 16'($urandom_range(40)));
                    write_reg(cts_pkg::CFG_TAIL_TIME, 16'($urandom_range(10)));
                    write_reg(cts_pkg::CFG_FULL_DUPLEX,
                              (phase == 4) ? 16'd0 : 16'($urandom_range(1)));
                end
                default: ;
            endcase

            if (phase == 0) begin
                // Ignored items while idle: reserved opcode, stray ready, idle tick.
                push_event(OP_RESERVED, 10'h3ff, 16'hffff, 8'hff, 1'b1, 1'b1);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b1);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'hffff, 8'd0, 1'b0, 1'b0);
                // Empty offer refused, then a frame taken and a second refused.
                push_event(cts_pkg::OP_FRAME_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_FRAME_READY, 10'd2, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_FRAME_READY, 10'h3ff, 16'd0, 8'd0, 1'b0, 1'b0);
                // Partial tick, busy channel, failed then passed persistence.
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd3, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd7, 8'd0, 1'b1, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd10, 8'd255, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd10, 8'd63, 1'b0, 1'b0);
                // Ready during key-up delay is ignored; the delay runs out.
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'hffff, 8'd0, 1'b0, 1'b0);
                // Underrun rewind and restart of the frame.
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b1);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                // Frame offered during flush; underrun flag in flush is ignored.
                push_event(cts_pkg::OP_FRAME_READY, 10'd1, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b1);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                // Frame offered during the tail goes back to the key-up delay.
                push_event(cts_pkg::OP_FRAME_READY, 10'd1, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd1, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TX_READY, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                // Zero-length tick in the tail, then the key is released.
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd0, 8'd0, 1'b0, 1'b0);
                push_event(cts_pkg::OP_TIMER_TICK, 10'd0, 16'd4, 8'd0, 1'b0, 1'b0);
            end

            queue_traffic(ITEMS_PER_PHASE);

            // Let every item through and every result out before going on.
            do @(negedge aclk);
            while (tx_events_q.size() != 0 || s_tvalid || line_cmds_q.size() != 0);
        end

        // Run on to catch any result item nobody asked for.
        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("** csma_transmit_sequencer: PASSED **");
        end else begin
            $display("** csma_transmit_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
